// File: hw/rtl/sch_pkg.sv
`timescale 1ns / 1ps
package sch_pkg;

    // Input item kinds.
    localparam logic [2:0] KIND_LOAD_USER = 3'd0;
    localparam logic [2:0] KIND_LOAD_PASS = 3'd1;
    localparam logic [2:0] KIND_LOAD_NAME = 3'd2;
    localparam logic [2:0] KIND_LOAD_IPV6 = 3'd3;
    localparam logic [2:0] KIND_START     = 3'd4;
    localparam logic [2:0] KIND_RECEIVE   = 3'd5;
    localparam logic [2:0] KIND_PULL      = 3'd6;

    // Status codes.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_VERSION = 4'd1;
    localparam logic [3:0] ST_BAD_METHOD  = 4'd2;
    localparam logic [3:0] ST_BAD_AUTHVER = 4'd3;
    localparam logic [3:0] ST_AUTH_ERROR  = 4'd4;
    localparam logic [3:0] ST_USER_REQ    = 4'd5;
    localparam logic [3:0] ST_GENERAL     = 4'd6;
    localparam logic [3:0] ST_CMD_UNSUPP  = 4'd7;
    localparam logic [3:0] ST_NO_IDENTD   = 4'd8;
    localparam logic [3:0] ST_IDENTD_ERR  = 4'd9;
    localparam logic [3:0] ST_NO_PERMIT   = 4'd10;
    localparam logic [3:0] ST_NET_UNREACH = 4'd11;
    localparam logic [3:0] ST_HOST_UNREACH = 4'd12;
    localparam logic [3:0] ST_REFUSED     = 4'd13;
    localparam logic [3:0] ST_TIMEOUT     = 4'd14;
    localparam logic [3:0] ST_FAMILY      = 4'd15;

    // Register indexes.
    localparam logic [2:0] REG_VERSION  = 3'd0;
    localparam logic [2:0] REG_COMMAND  = 3'd1;
    localparam logic [2:0] REG_USER_LEN = 3'd2;
    localparam logic [2:0] REG_PASS_LEN = 3'd3;
    localparam logic [2:0] REG_NAME_LEN = 3'd4;
    localparam logic [2:0] REG_IPV4     = 3'd5;
    localparam logic [2:0] REG_PORT     = 3'd6;
    localparam logic [2:0] REG_USE_IPV6 = 3'd7;

    localparam logic [1:0] CMD_BIND = 2'd2;

    localparam logic [7:0] V4_GRANTED  = 8'd90;
    localparam logic [7:0] V4_REJECTED = 8'd91;
    localparam logic [7:0] V4_NO_IDENT = 8'd92;
    localparam logic [7:0] V4_IDENT_ERR = 8'd93;

    localparam logic [7:0] ATYP_IPV4 = 8'd1;
    localparam logic [7:0] ATYP_NAME = 8'd3;
    localparam logic [7:0] ATYP_IPV6 = 8'd4;

endpackage

// File: hw/rtl/socks_client_handshake.sv
`timescale 1ns / 1ps
// SOCKS4/SOCKS5 client handshake engine, one byte per request.
// Input channel (s_*): a request is a load of the user, password, name or
// IPv6 store, a start, a byte received from the proxy, or a pull of the
// next byte to send. Every request yields exactly one result on the m_*
// channel: the transmit byte with its last-of-message flag, and on the
// request that ends the handshake done_res with the status and, for bind,
// the bound address and port when the reply carries an IPv4 address.
// The result is registered: it shows in the cycle after the request is
// accepted. One request per cycle is sustained while results are taken and
// no APB write holds the input off; the state update and the byte select sit
// between the state registers and the result register. The string stores
// are RAMs read ahead at the address the next pull will need, so the
// input is held off during the access cycle of each APB write and in the
// cycle after it while that read is redone with the new lengths.
// If the result is not taken, s_ready follows m_ready, so the request
// behind it waits without loss. Synchronous reset returns the engine to
// idle with the default registers (version 5, connect); store contents
// are left as they were and must be loaded before use.
module socks_client_handshake #(
    parameter int STRING_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_index,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_last,
    output logic        m_done_res,
    output logic [3:0]  m_status,
    output logic [31:0] m_bound_address,
    output logic [15:0] m_bound_port,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sch_pkg::*;

    localparam int AW = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;
    localparam logic [9:0] DEPTH10 = 10'(STRING_DEPTH);

    typedef enum logic [3:0] {
        PH_IDLE, PH_GREET, PH_METHOD, PH_AUTH_TX, PH_AUTH_RX,
        PH_REQ5, PH_REPLY5, PH_EXTRA5, PH_REQ4, PH_REPLY4
    } phase_t;

    // Configuration registers.
    logic [3:0]  version_reg;
    logic [1:0]  command_reg;
    logic [7:0]  user_len_reg, pass_len_reg, name_len_reg;
    logic [31:0] ipv4_reg;
    logic [15:0] port_reg;
    logic        use_ipv6_reg;
    logic        cfg_hold_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg  <= 4'd5;
            command_reg  <= 2'd1;
            user_len_reg <= '0;
            pass_len_reg <= '0;
            name_len_reg <= '0;
            ipv4_reg     <= '0;
            port_reg     <= '0;
            use_ipv6_reg <= 1'b0;
            cfg_hold_reg <= 1'b0;
        end else begin
            cfg_hold_reg <= cfg_wr;
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_VERSION:  version_reg  <= pwdata[3:0];
                    REG_COMMAND:  command_reg  <= pwdata[1:0];
                    REG_USER_LEN: user_len_reg <= pwdata[7:0];
                    REG_PASS_LEN: pass_len_reg <= pwdata[7:0];
                    REG_NAME_LEN: name_len_reg <= pwdata[7:0];
                    REG_IPV4:     ipv4_reg     <= pwdata;
                    REG_PORT:     port_reg     <= pwdata[15:0];
                    REG_USE_IPV6: use_ipv6_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_VERSION:  prdata = {28'd0, version_reg};
            REG_COMMAND:  prdata = {30'd0, command_reg};
            REG_USER_LEN: prdata = {24'd0, user_len_reg};
            REG_PASS_LEN: prdata = {24'd0, pass_len_reg};
            REG_NAME_LEN: prdata = {24'd0, name_len_reg};
            REG_IPV4:     prdata = ipv4_reg;
            REG_PORT:     prdata = {16'd0, port_reg};
            REG_USE_IPV6: prdata = {31'd0, use_ipv6_reg};
            default:      prdata = '0;
        endcase
    end

    // Handshake state.
    phase_t      phase_reg, phase_next;
    logic [9:0]  tx_cnt_reg, tx_cnt_next;
    logic [3:0]  rx_cnt_reg, rx_cnt_next;
    logic [8:0]  extra_reg, extra_next;
    logic        bind2_reg, bind2_next;
    logic [7:0]  reply_reg [10];
    logic [7:0]  reply_next [10];

    // Stores and their look-ahead read data.
    logic [7:0] user_mem [STRING_DEPTH];
    logic [7:0] pass_mem [STRING_DEPTH];
    logic [7:0] name_mem [STRING_DEPTH];
    logic [7:0] ipv6_mem [16];
    logic [7:0] user_rd_reg, pass_rd_reg, name_rd_reg;

    logic accept;
    logic out_valid_reg;
    logic load_ok;

    assign s_ready = (!out_valid_reg || m_ready) && !cfg_wr && !cfg_hold_reg;
    assign accept  = s_valid && s_ready;
    assign load_ok = {1'b0, s_index} < 9'(STRING_DEPTH);

    // Result of this request.
    logic        r_txv, r_txl, r_done;
    logic [7:0]  r_txb;
    logic [3:0]  r_status;
    logic [31:0] r_addr;
    logic [15:0] r_port;

    // Pull byte selection.
    logic [9:0] msg_len, ua, pa, na;
    logic [9:0] ul10, pl10, nl10, alen;
    logic [7:0] msg_b, ipv4_b, user_b, pass_b, name_b;
    logic [9:0] k4;

    assign ul10 = {2'd0, user_len_reg};
    assign pl10 = {2'd0, pass_len_reg};
    assign nl10 = {2'd0, name_len_reg};
    assign alen = (name_len_reg != 8'd0) ? nl10 + 10'd1 : (use_ipv6_reg ? 10'd16 : 10'd4);
    assign ua = (phase_reg == PH_AUTH_TX) ? tx_cnt_reg - 10'd2 : tx_cnt_reg - 10'd8;
    assign pa = tx_cnt_reg - 10'd3 - ul10;
    assign na = tx_cnt_reg - 10'd5;
    assign k4 = (phase_reg == PH_REQ4) ? tx_cnt_reg - 10'd4 : tx_cnt_reg - 10'd4;
    assign user_b = (ua < DEPTH10) ? user_rd_reg : 8'd0;
    assign pass_b = (pa < DEPTH10) ? pass_rd_reg : 8'd0;
    assign name_b = (na < DEPTH10) ? name_rd_reg : 8'd0;

    always_comb begin
        case (k4[1:0])
            2'd0:    ipv4_b = ipv4_reg[31:24];
            2'd1:    ipv4_b = ipv4_reg[23:16];
            2'd2:    ipv4_b = ipv4_reg[15:8];
            default: ipv4_b = ipv4_reg[7:0];
        endcase
    end

    always_comb begin
        msg_len = 10'd0;
        msg_b   = 8'd0;
        case (phase_reg)
            PH_GREET: begin
                msg_len = (user_len_reg != 8'd0) ? 10'd4 : 10'd3;
                case (tx_cnt_reg)
                    10'd0:   msg_b = 8'd5;
                    10'd1:   msg_b = (user_len_reg != 8'd0) ? 8'd2 : 8'd1;
                    10'd3:   msg_b = 8'd2;
                    default: msg_b = 8'd0;
                endcase
            end
            PH_AUTH_TX: begin
                msg_len = ul10 + pl10 + 10'd3;
                if (tx_cnt_reg == 10'd0)
                    msg_b = 8'd1;
                else if (tx_cnt_reg == 10'd1)
                    msg_b = user_len_reg;
                else if (tx_cnt_reg < ul10 + 10'd2)
                    msg_b = user_b;
                else if (tx_cnt_reg == ul10 + 10'd2)
                    msg_b = pass_len_reg;
                else
                    msg_b = pass_b;
            end
            PH_REQ5: begin
                msg_len = alen + 10'd6;
                if (tx_cnt_reg == 10'd0)
                    msg_b = 8'd5;
                else if (tx_cnt_reg == 10'd1)
                    msg_b = {6'd0, command_reg};
                else if (tx_cnt_reg == 10'd2)
                    msg_b = 8'd0;
                else if (tx_cnt_reg == 10'd3)
                    msg_b = (name_len_reg != 8'd0) ? ATYP_NAME :
                            (use_ipv6_reg ? ATYP_IPV6 : ATYP_IPV4);
                else if (tx_cnt_reg < alen + 10'd4) begin
                    if (name_len_reg != 8'd0)
                        msg_b = (tx_cnt_reg == 10'd4) ? name_len_reg : name_b;
                    else if (use_ipv6_reg)
                        msg_b = ipv6_mem[k4[3:0]];
                    else
                        msg_b = ipv4_b;
                end else if (tx_cnt_reg == alen + 10'd4)
                    msg_b = port_reg[15:8];
                else if (tx_cnt_reg == alen + 10'd5)
                    msg_b = port_reg[7:0];
                else
                    msg_b = 8'd0;
            end
            default: begin
                msg_len = ul10 + 10'd9;
                if (tx_cnt_reg == 10'd0)
                    msg_b = 8'd4;
                else if (tx_cnt_reg == 10'd1)
                    msg_b = {6'd0, command_reg};
                else if (tx_cnt_reg == 10'd2)
                    msg_b = port_reg[15:8];
                else if (tx_cnt_reg == 10'd3)
                    msg_b = port_reg[7:0];
                else if (tx_cnt_reg < 10'd8)
                    msg_b = ipv4_b;
                else if (tx_cnt_reg < ul10 + 10'd8)
                    msg_b = user_b;
                else
                    msg_b = 8'd0;
            end
        endcase
    end

    // Next state.
    logic       fin, acc, acc_v4form, acc_has_v4;
    logic [3:0] fin_st;
    phase_t     acc_ph;
    logic [7:0] code, atyp;

    always_comb begin
        phase_next  = phase_reg;
        tx_cnt_next = tx_cnt_reg;
        rx_cnt_next = rx_cnt_reg;
        extra_next  = extra_reg;
        bind2_next  = bind2_reg;
        for (int i = 0; i < 10; i++) reply_next[i] = reply_reg[i];
        r_txv = 1'b0;
        r_txb = 8'd0;
        r_txl = 1'b0;
        fin = 1'b0;
        fin_st = ST_OK;
        acc = 1'b0;
        acc_ph = PH_REPLY5;
        acc_v4form = 1'b0;
        acc_has_v4 = 1'b0;
        code = 8'd0;
        atyp = 8'd0;
        case (s_kind)
            KIND_START: begin
                tx_cnt_next = '0;
                rx_cnt_next = '0;
                extra_next  = '0;
                bind2_next  = 1'b0;
                for (int i = 0; i < 10; i++) reply_next[i] = 8'd0;
                if (version_reg == 4'd5)
                    phase_next = PH_GREET;
                else if (version_reg == 4'd4) begin
                    if (use_ipv6_reg) begin
                        fin = 1'b1;
                        fin_st = ST_FAMILY;
                    end else
                        phase_next = PH_REQ4;
                end else begin
                    fin = 1'b1;
                    fin_st = ST_BAD_VERSION;
                end
            end
            KIND_RECEIVE: begin
                if (phase_reg == PH_EXTRA5) begin
                    extra_next = extra_reg - 9'd1;
                    if (extra_next == 9'd0)
                        acc = 1'b1;
                end else if (phase_reg == PH_METHOD || phase_reg == PH_AUTH_RX ||
                             phase_reg == PH_REPLY5 || phase_reg == PH_REPLY4) begin
                    if (rx_cnt_reg < 4'd10)
                        reply_next[rx_cnt_reg] = s_data_byte;
                    rx_cnt_next = rx_cnt_reg + 4'd1;
                    code = reply_next[1];
                    atyp = reply_next[3];
                    if (phase_reg == PH_METHOD && rx_cnt_next == 4'd2) begin
                        if (reply_next[0] < 8'd5) begin
                            fin = 1'b1;
                            fin_st = ST_BAD_VERSION;
                        end else if (code == 8'd0) begin
                            phase_next = PH_REQ5;
                            tx_cnt_next = '0;
                            rx_cnt_next = '0;
                        end else if (code == 8'd2) begin
                            if (user_len_reg == 8'd0) begin
                                fin = 1'b1;
                                fin_st = ST_USER_REQ;
                            end else begin
                                phase_next = PH_AUTH_TX;
                                tx_cnt_next = '0;
                            end
                        end else begin
                            fin = 1'b1;
                            fin_st = ST_BAD_METHOD;
                        end
                    end else if (phase_reg == PH_AUTH_RX && rx_cnt_next == 4'd2) begin
                        if (reply_next[0] != 8'd1) begin
                            fin = 1'b1;
                            fin_st = ST_BAD_AUTHVER;
                        end else if (code != 8'd0) begin
                            fin = 1'b1;
                            fin_st = ST_AUTH_ERROR;
                        end else begin
                            phase_next = PH_REQ5;
                            tx_cnt_next = '0;
                            rx_cnt_next = '0;
                        end
                    end else if (phase_reg == PH_REPLY5 && rx_cnt_next == 4'd10) begin
                        if (reply_next[0] < 8'd5) begin
                            fin = 1'b1;
                            fin_st = ST_BAD_VERSION;
                        end else if (code != 8'd0) begin
                            fin = 1'b1;
                            case (code)
                                8'd2:    fin_st = ST_NO_PERMIT;
                                8'd3:    fin_st = ST_NET_UNREACH;
                                8'd4:    fin_st = ST_HOST_UNREACH;
                                8'd5:    fin_st = ST_REFUSED;
                                8'd6:    fin_st = ST_TIMEOUT;
                                8'd7:    fin_st = ST_CMD_UNSUPP;
                                8'd8:    fin_st = ST_FAMILY;
                                default: fin_st = ST_GENERAL;
                            endcase
                        end else if (atyp == ATYP_IPV4) begin
                            acc = 1'b1;
                            acc_has_v4 = 1'b1;
                        end else if (atyp == ATYP_IPV6) begin
                            extra_next = 9'd12;
                            phase_next = PH_EXTRA5;
                        end else if (atyp == ATYP_NAME) begin
                            if (reply_next[4] > 8'd3) begin
                                extra_next = {1'b0, reply_next[4] - 8'd3};
                                phase_next = PH_EXTRA5;
                            end else
                                acc = 1'b1;
                        end else begin
                            fin = 1'b1;
                            fin_st = ST_FAMILY;
                        end
                    end else if (phase_reg == PH_REPLY4 && rx_cnt_next == 4'd8) begin
                        if (reply_next[0] != 8'd0) begin
                            fin = 1'b1;
                            fin_st = ST_GENERAL;
                        end else if (code == V4_GRANTED) begin
                            acc = 1'b1;
                            acc_ph = PH_REPLY4;
                            acc_v4form = 1'b1;
                            acc_has_v4 = 1'b1;
                        end else begin
                            fin = 1'b1;
                            if (code == V4_REJECTED)
                                fin_st = ST_AUTH_ERROR;
                            else if (code == V4_NO_IDENT)
                                fin_st = ST_NO_IDENTD;
                            else if (code == V4_IDENT_ERR)
                                fin_st = ST_IDENTD_ERR;
                            else
                                fin_st = ST_GENERAL;
                        end
                    end
                end
            end
            KIND_PULL: begin
                if (phase_reg == PH_GREET || phase_reg == PH_AUTH_TX ||
                    phase_reg == PH_REQ5 || phase_reg == PH_REQ4) begin
                    r_txv = 1'b1;
                    r_txb = (tx_cnt_reg < msg_len) ? msg_b : 8'd0;
                    r_txl = (tx_cnt_reg + 10'd1) >= msg_len;
                    tx_cnt_next = tx_cnt_reg + 10'd1;
                    if (r_txl) begin
                        tx_cnt_next = '0;
                        rx_cnt_next = '0;
                        case (phase_reg)
                            PH_GREET:   phase_next = PH_METHOD;
                            PH_AUTH_TX: phase_next = PH_AUTH_RX;
                            PH_REQ5:    phase_next = PH_REPLY5;
                            default:    phase_next = PH_REPLY4;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        r_addr = '0;
        r_port = '0;
        if (acc) begin
            if (command_reg == CMD_BIND && !bind2_reg) begin
                bind2_next = 1'b1;
                rx_cnt_next = '0;
                phase_next = acc_ph;
            end else begin
                fin = 1'b1;
                fin_st = ST_OK;
                if (command_reg == CMD_BIND && acc_has_v4) begin
                    r_addr = {reply_next[4], reply_next[5], reply_next[6], reply_next[7]};
                    r_port = acc_v4form ? {reply_next[2], reply_next[3]}
                                        : {reply_next[8], reply_next[9]};
                end
            end
        end
        r_done = fin;
        r_status = fin ? fin_st : ST_OK;
        if (fin)
            phase_next = PH_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tx_cnt_reg    <= '0;
            rx_cnt_reg    <= '0;
            extra_reg     <= '0;
            bind2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 10; i++) reply_reg[i] <= 8'd0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                tx_cnt_reg <= tx_cnt_next;
                rx_cnt_reg <= rx_cnt_next;
                extra_reg  <= extra_next;
                bind2_reg  <= bind2_next;
                for (int i = 0; i < 10; i++) reply_reg[i] <= reply_next[i];
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tx_valid      <= r_txv;
            m_tx_byte       <= r_txb;
            m_tx_last       <= r_txl;
            m_done_res      <= r_done;
            m_status        <= r_status;
            m_bound_address <= r_addr;
            m_bound_port    <= r_port;
        end
    end

    assign m_valid = out_valid_reg;

    // Look-ahead store reads at the positions the next pull will use.
    phase_t     ph_la;
    logic [9:0] tx_la, ua_la, pa_la, na_la;
    logic       wr_user, wr_pass, wr_name;

    assign ph_la = accept ? phase_next : phase_reg;
    assign tx_la = accept ? tx_cnt_next : tx_cnt_reg;
    assign ua_la = (ph_la == PH_AUTH_TX) ? tx_la - 10'd2 : tx_la - 10'd8;
    assign pa_la = tx_la - 10'd3 - ul10;
    assign na_la = tx_la - 10'd5;
    assign wr_user = accept && s_kind == KIND_LOAD_USER && load_ok;
    assign wr_pass = accept && s_kind == KIND_LOAD_PASS && load_ok;
    assign wr_name = accept && s_kind == KIND_LOAD_NAME && load_ok;

    always_ff @(posedge aclk) begin
        if (wr_user)
            user_mem[s_index[AW-1:0]] <= s_data_byte;
        if (wr_user && s_index[AW-1:0] == ua_la[AW-1:0])
            user_rd_reg <= s_data_byte;
        else
            user_rd_reg <= user_mem[ua_la[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_pass)
            pass_mem[s_index[AW-1:0]] <= s_data_byte;
        if (wr_pass && s_index[AW-1:0] == pa_la[AW-1:0])
            pass_rd_reg <= s_data_byte;
        else
            pass_rd_reg <= pass_mem[pa_la[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_name)
            name_mem[s_index[AW-1:0]] <= s_data_byte;
        if (wr_name && s_index[AW-1:0] == na_la[AW-1:0])
            name_rd_reg <= s_data_byte;
        else
            name_rd_reg <= name_mem[na_la[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_kind == KIND_LOAD_IPV6 && s_index < 8'd16)
            ipv6_mem[s_index[3:0]] <= s_data_byte;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sch_pkg::*;

    typedef enum logic [3:0] {
        HS_IDLE, HS_GREET, HS_METHOD, HS_AUTH_TX, HS_AUTH_RX,
        HS_REQ5, HS_REPLY5, HS_EXTRA5, HS_REQ4, HS_REPLY4
    } hs_phase_e;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        done_res;
        logic [3:0]  status;
        logic [31:0] bound_address;
        logic [15:0] bound_port;
    } hs_result_t;

    typedef struct {
        logic        is_reg;
        logic [2:0]  sel;
        logic [31:0] value;
        logic [7:0]  index;
        logic [7:0]  data;
        logic        typed;
        hs_result_t  exp;
    } script_row_t;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_kind;
    logic [7:0]  s_index;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_tx_last;
    logic        m_done_res;
    logic [3:0]  m_status;
    logic [31:0] m_bound_address;
    logic [15:0] m_bound_port;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    socks_client_handshake DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_index(s_index),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_tx_valid(m_tx_valid),
        .m_tx_byte(m_tx_byte), .m_tx_last(m_tx_last), .m_done_res(m_done_res),
        .m_status(m_status), .m_bound_address(m_bound_address),
        .m_bound_port(m_bound_port),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the handshake engine.
    logic [3:0]  sh_version;
    logic [1:0]  sh_command;
    logic [7:0]  sh_user_len, sh_pass_len, sh_name_len;
    logic [31:0] sh_ipv4;
    logic [15:0] sh_port;
    logic        sh_use_ipv6;
    hs_phase_e   hs_phase;
    logic [7:0]  user_mem [256];
    logic [7:0]  pass_mem [256];
    logic [7:0]  name_mem [256];
    logic [7:0]  ipv6_mem [16];
    logic [7:0]  reply_mem [10];
    int          rx_cnt, tx_cnt, extra_left;
    logic        second_reply;
    hs_result_t  step_out;

    hs_result_t  pending_results[$];
    script_row_t script[$];
    int          mismatches = 0;
    int          results_checked = 0;
    int          requests_sent = 0;
    int          random_requests = 0;
    int          handshakes_done = 0;
    int          cycles = 0;
    bit          gaps_on = 0;
    bit          hold_armed = 0;
    bit          hold_taken = 0;
    int          hold_cycles = 0;

    initial aclk = 0;
    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: long hold-offs are counted here, short stalls are random.
    always @(posedge aclk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= 299;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(99) < 20) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(negedge aclk) begin
        hs_result_t want;
        hs_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_tx_valid, m_tx_byte, m_tx_last, m_done_res, m_status,
                    m_bound_address, m_bound_port};
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p at cycle %0d", got, cycles);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch at cycle %0d: expected txv %0d byte %02h ",
                                  "last %0d done %0d st %0d addr %08h port %04h, got txv %0d ",
                                  "byte %02h last %0d done %0d st %0d addr %08h port %04h"},
                                 cycles, want.tx_valid, want.tx_byte, want.tx_last,
                                 want.done_res, want.status, want.bound_address,
                                 want.bound_port, got.tx_valid, got.tx_byte, got.tx_last,
                                 got.done_res, got.status, got.bound_address,
                                 got.bound_port);
                end
            end
        end
    end

    function automatic logic [7:0] ipv4_octet(int k);
        return sh_ipv4[8 * (3 - (k & 3)) +: 8];
    endfunction

    function automatic int message_length();
        case (hs_phase)
            HS_GREET:   return (sh_user_len != 0) ? 4 : 3;
            HS_AUTH_TX: return sh_user_len + sh_pass_len + 3;
            HS_REQ5:    return 6 + ((sh_name_len != 0) ? sh_name_len + 1 :
                                    (sh_use_ipv6 ? 16 : 4));
            default:    return 9 + sh_user_len;
        endcase
    endfunction

    function automatic logic [7:0] message_octet(int i);
        int alen;
        int k;
        if (hs_phase == HS_GREET) begin
            if (i == 0) return 8'd5;
            if (i == 1) return (sh_user_len != 0) ? 8'd2 : 8'd1;
            if (i == 3) return 8'd2;
            return 8'd0;
        end
        if (hs_phase == HS_AUTH_TX) begin
            if (i == 0) return 8'd1;
            if (i == 1) return sh_user_len;
            if (i < 2 + sh_user_len) return user_mem[i - 2];
            if (i == 2 + sh_user_len) return sh_pass_len;
            return pass_mem[i - 3 - sh_user_len];
        end
        if (hs_phase == HS_REQ5) begin
            alen = (sh_name_len != 0) ? sh_name_len + 1 : (sh_use_ipv6 ? 16 : 4);
            if (i == 0) return 8'd5;
            if (i == 1) return {6'd0, sh_command};
            if (i == 2) return 8'd0;
            if (i == 3) return (sh_name_len != 0) ? ATYP_NAME :
                               (sh_use_ipv6 ? ATYP_IPV6 : ATYP_IPV4);
            if (i < 4 + alen) begin
                k = i - 4;
                if (sh_name_len != 0) return (k == 0) ? sh_name_len : name_mem[k - 1];
                if (sh_use_ipv6) return ipv6_mem[k & 15];
                return ipv4_octet(k);
            end
            if (i == 4 + alen) return sh_port[15:8];
            if (i == 5 + alen) return sh_port[7:0];
            return 8'd0;
        end
        if (i == 0) return 8'd4;
        if (i == 1) return {6'd0, sh_command};
        if (i == 2) return sh_port[15:8];
        if (i == 3) return sh_port[7:0];
        if (i < 8) return ipv4_octet(i - 4);
        if (i < 8 + sh_user_len) return user_mem[i - 8];
        return 8'd0;
    endfunction

    function automatic void end_handshake(logic [3:0] st);
        step_out.done_res = 1'b1;
        step_out.status = st;
        hs_phase = HS_IDLE;
    endfunction

    function automatic void open_request();
        hs_phase = HS_REQ5;
        tx_cnt = 0;
        rx_cnt = 0;
    endfunction

    // A granted reply either arms the second bind reply or ends the handshake.
    function automatic void reply_granted(hs_phase_e again, bit v4form, bit has_v4);
        if (sh_command == CMD_BIND && !second_reply) begin
            second_reply = 1'b1;
            rx_cnt = 0;
            hs_phase = again;
            return;
        end
        end_handshake(ST_OK);
        if (sh_command == CMD_BIND && has_v4) begin
            step_out.bound_address = {reply_mem[4], reply_mem[5], reply_mem[6], reply_mem[7]};
            step_out.bound_port = v4form ? {reply_mem[2], reply_mem[3]} :
                                           {reply_mem[8], reply_mem[9]};
        end
    endfunction

    function automatic void judge_v5_reply();
        logic [7:0] code;
        logic [7:0] atyp;
        int extra;
        code = reply_mem[1];
        atyp = reply_mem[3];
        if (reply_mem[0] < 5) begin
            end_handshake(ST_BAD_VERSION);
            return;
        end
        if (code != 0) begin
            case (code)
                8'd2: end_handshake(ST_NO_PERMIT);
                8'd3: end_handshake(ST_NET_UNREACH);
                8'd4: end_handshake(ST_HOST_UNREACH);
                8'd5: end_handshake(ST_REFUSED);
                8'd6: end_handshake(ST_TIMEOUT);
                8'd7: end_handshake(ST_CMD_UNSUPP);
                8'd8: end_handshake(ST_FAMILY);
                default: end_handshake(ST_GENERAL);
            endcase
            return;
        end
        if (atyp == ATYP_IPV4) begin
            reply_granted(HS_REPLY5, 1'b0, 1'b1);
            return;
        end
        if (atyp == ATYP_IPV6) extra = 12;
        else if (atyp == ATYP_NAME) extra = (reply_mem[4] > 3) ? reply_mem[4] - 3 : 0;
        else begin
            end_handshake(ST_FAMILY);
            return;
        end
        if (extra == 0) begin
            reply_granted(HS_REPLY5, 1'b0, 1'b0);
            return;
        end
        extra_left = extra;
        hs_phase = HS_EXTRA5;
    endfunction

    function automatic void judge_v4_reply();
        if (reply_mem[0] != 0) end_handshake(ST_GENERAL);
        else if (reply_mem[1] == V4_GRANTED) reply_granted(HS_REPLY4, 1'b1, 1'b1);
        else if (reply_mem[1] == V4_REJECTED) end_handshake(ST_AUTH_ERROR);
        else if (reply_mem[1] == V4_NO_IDENT) end_handshake(ST_NO_IDENTD);
        else if (reply_mem[1] == V4_IDENT_ERR) end_handshake(ST_IDENTD_ERR);
        else end_handshake(ST_GENERAL);
    endfunction

    function automatic void take_reply_byte(logic [7:0] b);
        if (hs_phase == HS_EXTRA5) begin
            extra_left--;
            if (extra_left == 0) reply_granted(HS_REPLY5, 1'b0, 1'b0);
            return;
        end
        if (!(hs_phase inside {HS_METHOD, HS_AUTH_RX, HS_REPLY5, HS_REPLY4})) return;
        if (rx_cnt < 10) reply_mem[rx_cnt] = b;
        rx_cnt++;
        if (hs_phase == HS_METHOD && rx_cnt == 2) begin
            if (reply_mem[0] < 5) end_handshake(ST_BAD_VERSION);
            else if (reply_mem[1] == 0) open_request();
            else if (reply_mem[1] == 2) begin
                if (sh_user_len == 0) end_handshake(ST_USER_REQ);
                else begin
                    hs_phase = HS_AUTH_TX;
                    tx_cnt = 0;
                end
            end else end_handshake(ST_BAD_METHOD);
        end else if (hs_phase == HS_AUTH_RX && rx_cnt == 2) begin
            if (reply_mem[0] != 1) end_handshake(ST_BAD_AUTHVER);
            else if (reply_mem[1] != 0) end_handshake(ST_AUTH_ERROR);
            else open_request();
        end else if (hs_phase == HS_REPLY5 && rx_cnt == 10) begin
            judge_v5_reply();
        end else if (hs_phase == HS_REPLY4 && rx_cnt == 8) begin
            judge_v4_reply();
        end
    endfunction

    function automatic hs_result_t advance_handshake(logic [2:0] k, logic [7:0] i,
                                                     logic [7:0] d);
        int len;
        step_out = '0;
        case (k)
            KIND_LOAD_USER: user_mem[i] = d;
            KIND_LOAD_PASS: pass_mem[i] = d;
            KIND_LOAD_NAME: name_mem[i] = d;
            KIND_LOAD_IPV6: if (i < 16) ipv6_mem[i[3:0]] = d;
            KIND_START: begin
                tx_cnt = 0;
                rx_cnt = 0;
                extra_left = 0;
                second_reply = 1'b0;
                foreach (reply_mem[n]) reply_mem[n] = 8'd0;
                if (sh_version == 4'd5) hs_phase = HS_GREET;
                else if (sh_version == 4'd4) begin
                    if (sh_use_ipv6) end_handshake(ST_FAMILY);
                    else hs_phase = HS_REQ4;
                end else end_handshake(ST_BAD_VERSION);
            end
            KIND_RECEIVE: take_reply_byte(d);
            KIND_PULL: begin
                if (hs_phase inside {HS_GREET, HS_AUTH_TX, HS_REQ5, HS_REQ4}) begin
                    len = message_length();
                    step_out.tx_valid = 1'b1;
                    step_out.tx_byte = (tx_cnt < len) ? message_octet(tx_cnt) : 8'd0;
                    step_out.tx_last = (tx_cnt + 1 >= len);
                    tx_cnt++;
                    if (step_out.tx_last) begin
                        tx_cnt = 0;
                        rx_cnt = 0;
                        case (hs_phase)
                            HS_GREET:   hs_phase = HS_METHOD;
                            HS_AUTH_TX: hs_phase = HS_AUTH_RX;
                            HS_REQ5:    hs_phase = HS_REPLY5;
                            default:    hs_phase = HS_REPLY4;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        if (step_out.done_res) handshakes_done++;
        return step_out;
    endfunction

    task automatic send_request(logic [2:0] k, logic [7:0] i, logic [7:0] d,
                                bit typed = 0, hs_result_t fixed = '0);
        hs_result_t predicted;
        if (gaps_on && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_index <= i;
        s_data_byte <= d;
        forever begin
            @(negedge aclk);
            if (s_ready) begin
                predicted = advance_handshake(k, i, d);
                pending_results.push_back(typed ? fixed : predicted);
                requests_sent++;
                @(posedge aclk);
                break;
            end
            @(posedge aclk);
        end
    endtask

    // Lets every outstanding result come back before a register is touched.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_VERSION:  sh_version = v[3:0];
            REG_COMMAND:  sh_command = v[1:0];
            REG_USER_LEN: sh_user_len = v[7:0];
            REG_PASS_LEN: sh_pass_len = v[7:0];
            REG_NAME_LEN: sh_name_len = v[7:0];
            REG_IPV4:     sh_ipv4 = v;
            REG_PORT:     sh_port = v[15:0];
            default:      sh_use_ipv6 = v[0];
        endcase
    endtask

    function automatic void add_reg(logic [2:0] r, logic [31:0] v);
        script.push_back('{1'b1, r, v, 8'd0, 8'd0, 1'b0, '0});
    endfunction

    function automatic void add_req(logic [2:0] k, logic [7:0] i, logic [7:0] d);
        script.push_back('{1'b0, k, 32'd0, i, d, 1'b0, '0});
    endfunction

    function automatic void add_fixed(logic [2:0] k, logic [7:0] d, hs_result_t e);
        script.push_back('{1'b0, k, 32'd0, 8'd0, d, 1'b1, e});
    endfunction

    function automatic logic [7:0] pick_reply_byte();
        int pct;
        pct = $urandom_range(99);
        if (pct < 4) return 8'($urandom);
        case (hs_phase)
            HS_METHOD:
                if (rx_cnt == 0) return (pct < 8) ? 8'($urandom_range(7)) : 8'd5;
                else return (pct < 8) ? 8'($urandom_range(3)) :
                            ((sh_user_len != 0) ? 8'd2 : 8'd0);
            HS_AUTH_RX: return (rx_cnt == 0) ? 8'd1 : ((pct < 10) ? 8'd3 : 8'd0);
            HS_REPLY5:
                case (rx_cnt)
                    0: return (pct < 8) ? 8'($urandom_range(7)) : 8'd5;
                    1: return (pct < 75) ? 8'd0 :
                              ((pct < 95) ? 8'($urandom_range(1, 10)) : 8'($urandom));
                    3: return (pct < 60) ? ATYP_IPV4 : ((pct < 75) ? ATYP_NAME :
                              ((pct < 90) ? ATYP_IPV6 : 8'($urandom_range(7))));
                    4: return (reply_mem[3] == ATYP_NAME) ? 8'($urandom_range(12)) :
                              8'($urandom);
                    default: return 8'($urandom);
                endcase
            HS_REPLY4:
                case (rx_cnt)
                    0: return (pct < 92) ? 8'd0 : 8'($urandom_range(1, 255));
                    1: return (pct < 70) ? V4_GRANTED : ((pct < 78) ? V4_REJECTED :
                              ((pct < 86) ? V4_NO_IDENT :
                              ((pct < 94) ? V4_IDENT_ERR : 8'($urandom))));
                    default: return 8'($urandom);
                endcase
            default: return 8'($urandom);
        endcase
    endfunction

    // One start followed by whatever the handshake asks for, with some noise.
    task automatic run_handshake(int step_cap, bit counted);
        int steps;
        steps = 0;
        send_request(KIND_START, 8'($urandom), 8'($urandom));
        while (hs_phase != HS_IDLE && steps < step_cap) begin
            steps++;
            if ($urandom_range(99) < 3)
                send_request(3'($urandom), 8'($urandom), 8'($urandom));
            else if (hs_phase inside {HS_GREET, HS_AUTH_TX, HS_REQ5, HS_REQ4})
                send_request(KIND_PULL, 8'($urandom), 8'($urandom));
            else
                send_request(KIND_RECEIVE, 8'($urandom), pick_reply_byte());
            if (counted) random_requests++;
        end
    endtask

    task automatic random_settings();
        int pct;
        pct = $urandom_range(99);
        write_reg(REG_VERSION, (pct < 55) ? 5 : ((pct < 90) ? 4 : $urandom_range(15)));
        write_reg(REG_COMMAND, $urandom_range(1, 3));
        write_reg(REG_USER_LEN, ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15));
        write_reg(REG_PASS_LEN, $urandom_range(15));
        write_reg(REG_NAME_LEN, ($urandom_range(2) == 0) ? $urandom_range(1, 15) : 0);
        pct = $urandom_range(99);
        write_reg(REG_IPV4, (pct < 10) ? 32'hFFFF_FFFF : ((pct < 20) ? 0 : $urandom));
        pct = $urandom_range(99);
        write_reg(REG_PORT, (pct < 10) ? 16'hFFFF : ((pct < 20) ? 0 : $urandom_range(65535)));
        write_reg(REG_USE_IPV6, 32'($urandom_range(3) == 0));
    endtask

    initial begin
        int round;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = '0;
        s_index = '0;
        s_data_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sh_version = 4'd5;
        sh_command = 2'd1;
        sh_user_len = '0;
        sh_pass_len = '0;
        sh_name_len = '0;
        sh_ipv4 = '0;
        sh_port = '0;
        sh_use_ipv6 = 1'b0;
        hs_phase = HS_IDLE;
        rx_cnt = 0;
        tx_cnt = 0;
        extra_left = 0;
        second_reply = 1'b0;
        foreach (reply_mem[n]) reply_mem[n] = 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every store entry that a short length can reach is written first.
        for (int n = 0; n < 16; n++) begin
            send_request(KIND_LOAD_USER, 8'(n), 8'($urandom));
            send_request(KIND_LOAD_PASS, 8'(n), 8'($urandom));
            send_request(KIND_LOAD_NAME, 8'(n), 8'($urandom));
            send_request(KIND_LOAD_IPV6, 8'(n), 8'($urandom));
        end

        add_reg(REG_VERSION, 3);
        add_fixed(KIND_START, 0, '{1'b0, 8'd0, 1'b0, 1'b1, ST_BAD_VERSION, 32'd0, 16'd0});
        add_reg(REG_VERSION, 4);
        add_reg(REG_USE_IPV6, 1);
        add_fixed(KIND_START, 0, '{1'b0, 8'd0, 1'b0, 1'b1, ST_FAMILY, 32'd0, 16'd0});
        add_reg(REG_USE_IPV6, 0);
        add_fixed(3'd7, 8'hFF, '0);
        add_fixed(KIND_RECEIVE, 8'hFF, '0);
        add_fixed(KIND_PULL, 0, '0);
        add_req(KIND_LOAD_IPV6, 8'd200, 8'hA5);
        add_reg(REG_VERSION, 5);
        add_reg(REG_USER_LEN, 1);
        add_fixed(KIND_START, 0, '0);
        add_fixed(KIND_PULL, 0, '{1'b1, 8'd5, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0});
        add_fixed(KIND_PULL, 0, '{1'b1, 8'd2, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0});
        add_fixed(KIND_PULL, 0, '{1'b1, 8'd0, 1'b0, 1'b0, ST_OK, 32'd0, 16'd0});
        // The greeting shrinks under the pull, which then closes the message.
        add_reg(REG_USER_LEN, 0);
        add_fixed(KIND_PULL, 0, '{1'b1, 8'd0, 1'b1, 1'b0, ST_OK, 32'd0, 16'd0});
        add_fixed(KIND_RECEIVE, 8'd4, '0);
        add_fixed(KIND_RECEIVE, 8'd0, '{1'b0, 8'd0, 1'b0, 1'b1, ST_BAD_VERSION, 32'd0, 16'd0});
        add_req(KIND_START, 0, 0);
        add_req(KIND_PULL, 0, 0);
        add_req(KIND_PULL, 0, 0);
        add_req(KIND_PULL, 0, 0);
        add_req(KIND_RECEIVE, 0, 8'd5);
        add_fixed(KIND_RECEIVE, 8'd2, '{1'b0, 8'd0, 1'b0, 1'b1, ST_USER_REQ, 32'd0, 16'd0});
        add_req(KIND_START, 0, 0);
        add_req(KIND_PULL, 0, 0);
        add_req(KIND_PULL, 0, 0);
        add_req(KIND_PULL, 0, 0);
        add_req(KIND_RECEIVE, 0, 8'd5);
        add_fixed(KIND_RECEIVE, 8'h80, '{1'b0, 8'd0, 1'b0, 1'b1, ST_BAD_METHOD, 32'd0, 16'd0});

        foreach (script[n]) begin
            if (script[n].is_reg) begin
                drain();
                write_reg(script[n].sel, script[n].value);
            end else begin
                send_request(script[n].sel, script[n].index, script[n].data,
                             script[n].typed, script[n].exp);
            end
        end

        round = 0;
        while (random_requests < 400) begin
            drain();
            gaps_on = !(round >= 3 && round <= 6);
            if (round == 8) begin
                // Longest messages: full stores and the top lengths.
                gaps_on = 1;
                for (int n = 16; n < 256; n++) begin
                    send_request(KIND_LOAD_USER, 8'(n), 8'($urandom));
                    send_request(KIND_LOAD_PASS, 8'(n), 8'($urandom));
                    send_request(KIND_LOAD_NAME, 8'(n), 8'($urandom));
                end
                drain();
                write_reg(REG_VERSION, 5);
                write_reg(REG_COMMAND, 32'(CMD_BIND));
                write_reg(REG_USER_LEN, 255);
                write_reg(REG_PASS_LEN, 255);
                write_reg(REG_NAME_LEN, 255);
                write_reg(REG_IPV4, 32'hFFFF_FFFF);
                write_reg(REG_PORT, 16'hFFFF);
                write_reg(REG_USE_IPV6, 1);
                run_handshake(3000, 0);
                drain();
                write_reg(REG_VERSION, 4);
                write_reg(REG_USE_IPV6, 0);
                run_handshake(3000, 0);
            end else begin
                random_settings();
                // The result side holds off while requests keep coming.
                if (round == 5) hold_armed = 1;
                run_handshake(400, 1);
            end
            round++;
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("Covered %0d requests over %0d setting rounds, %0d handshakes ended.",
                 requests_sent, round, handshakes_done);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
